[rtl/mpwe_pkg.sv]
// shared types, opcodes and constant-divisor helpers for the motor parameter write encoder
package mpwe_pkg;

  typedef enum logic [3:0] {
    OP_SENS     = 4'd0,
    OP_FFB_STR  = 4'd1,
    OP_SCALE    = 4'd2,
    OP_DAMPER   = 4'd3,
    OP_FRICTION = 4'd4,
    OP_INERTIA  = 4'd5,
    OP_FILTER   = 4'd6,
    OP_EFF_INT  = 4'd7,
    OP_EFF_STR  = 4'd8,
    OP_SPR_STR  = 4'd9,
    OP_DMP_STR  = 4'd10
  } op_e;

  localparam logic [1:0] CFG_EXTENDED = 2'd0;
  localparam logic [1:0] CFG_MIRROR   = 2'd1;
  localparam logic [1:0] CFG_STRENGTH = 2'd2;

  localparam logic [7:0]  STRENGTH_RESET = 8'd100;
  localparam logic [7:0]  PCT_MAX        = 8'd100;
  localparam logic [11:0] DEG_MIN        = 12'd90;
  localparam logic [11:0] DEG_MAX        = 12'd2520;
  localparam logic [11:0] DEG_SPLIT      = 12'd1000;
  localparam logic [11:0] DEG_BIAS       = 12'd1270;
  localparam logic [7:0]  SENS_OFFSET    = 8'd129;   // -127 mod 256
  localparam logic [7:0]  LINEAR_CODE    = 8'haa;
  localparam logic [4:0]  FILTER_MAX     = 5'd20;
  localparam logic [4:0]  FILTER_MIRROR  = 5'd10;
  localparam logic [4:0]  FILTER_KNEE    = 5'd9;
  localparam logic [7:0]  EFFECT_MAX     = 8'd12;
  localparam logic [7:0]  ADDR_BASE      = 8'h20;

  // floor(x/100) for x < 2^23 by reciprocal multiply
  localparam logic [23:0] DIV100_MUL   = 24'd10737419;
  localparam int          DIV100_SHIFT = 30;
  // floor(x/10) for x < 2^12
  localparam logic [12:0] DIV10_MUL    = 13'd6554;
  localparam int          DIV10_SHIFT  = 16;

  typedef struct packed {
    op_e         op;
    logic        ok;
    logic [7:0]  lo;
    logic [6:0]  vcap;
    logic [11:0] deg;
    logic        lin;
    logic [22:0] p0;
    logic [6:0]  rampc;
    logic [6:0]  strc;
  } front_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
    op_e        op;
    logic [7:0] d0;
  } meta_t;

  function automatic logic [15:0] div100(input logic [22:0] x);
    logic [46:0] prod;
    prod = 47'(x) * 47'(DIV100_MUL);
    return prod[DIV100_SHIFT +: 16];
  endfunction

  function automatic logic [7:0] div10(input logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(DIV10_MUL);
    return prod[DIV10_SHIFT +: 8];
  endfunction

endpackage

[rtl/mpwe_front.sv]
// input stage: clamps, opcode check and first friction product
module mpwe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            ext_en_i,
  input  logic [7:0]      strength_i,
  input  logic [3:0]      op_i,
  input  logic [15:0]     setting_value_i,
  input  logic            auto_rotation_i,
  input  logic [15:0]     auto_degrees_i,
  input  logic [7:0]      ramp_percent_i,
  input  logic            calibration_active_i,
  input  logic            linear_scale_i,
  output logic            valid_o,
  output mpwe_pkg::front_t front_o
);
  import mpwe_pkg::*;

  logic   valid_q;
  front_t front_q, front_d;

  always_comb begin
    logic [15:0] deg_raw;
    logic [7:0]  lo;
    op_e         op;
    deg_raw = auto_rotation_i ? auto_degrees_i : setting_value_i;
    lo      = setting_value_i[7:0];
    op      = op_e'(op_i);

    front_d.op = op;
    front_d.ok = (op_i <= OP_DMP_STR) &&
                 !(!ext_en_i && (op == OP_SCALE || op == OP_INERTIA || op == OP_FILTER));
    front_d.lo = lo;
    front_d.vcap = (lo > PCT_MAX) ? PCT_MAX[6:0] : lo[6:0];
    if (deg_raw < 16'(DEG_MIN)) begin
      front_d.deg = DEG_MIN;
    end else if (deg_raw > 16'(DEG_MAX)) begin
      front_d.deg = DEG_MAX;
    end else begin
      front_d.deg = deg_raw[11:0];
    end
    front_d.lin   = linear_scale_i | calibration_active_i;
    // v * 65535 as a shift and subtract
    front_d.p0    = {front_d.vcap, 16'd0} - 23'(front_d.vcap);
    front_d.rampc = (ramp_percent_i > PCT_MAX) ? PCT_MAX[6:0] : ramp_percent_i[6:0];
    front_d.strc  = (strength_i > PCT_MAX) ? PCT_MAX[6:0] : strength_i[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

[rtl/mpwe_fric.sv]
// friction scaling chain: alternating multiply and divide-by-100 stages
module mpwe_fric (
  input  logic        clk_i,
  input  logic [22:0] p0_i,
  input  logic [6:0]  ramp_i,
  input  logic [6:0]  str_i,
  output logic [15:0] word_o
);
  import mpwe_pkg::*;

  logic [15:0] q1_q, q2_q, q3_q;
  logic [22:0] p2_q, p3_q;
  logic [6:0]  ramp1_q;
  logic [6:0]  str1_q, str2_q, str3_q;

  always_ff @(posedge clk_i) begin
    q1_q    <= div100(p0_i);
    ramp1_q <= ramp_i;
    str1_q  <= str_i;

    p2_q    <= 23'(q1_q) * 23'(ramp1_q);
    str2_q  <= str1_q;

    q2_q    <= div100(p2_q);
    str3_q  <= str2_q;

    p3_q    <= 23'(q2_q) * 23'(str3_q);

    q3_q    <= div100(p3_q);
  end

  assign word_o = q3_q;

endmodule

[rtl/motor_param_write_encoder_core.sv]
// top level: config registers, byte encoding stage, item alignment and result register
// a result strobes on done_o once its start_i edge has passed the front register, the
// five-stage friction multiply/divide chain and the result register, in that order
// throughput: one item per cycle, every stage is a plain register that never stalls
// busy_o stays low; results cannot be held off and leave one per cycle in order
// reset clears the valid line and sets extended off, mirror off, strength 100
module motor_param_write_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [3:0]  op_i,
  input  logic [15:0] setting_value_i,
  input  logic        auto_rotation_i,
  input  logic [15:0] auto_degrees_i,
  input  logic [7:0]  ramp_percent_i,
  input  logic        calibration_active_i,
  input  logic        linear_scale_i,
  output logic        done_o,
  output logic        supported_o,
  output logic [7:0]  motor_address_o,
  output logic [1:0]  write_length_o,
  output logic [7:0]  data_low_o,
  output logic [7:0]  data_high_o
);
  import mpwe_pkg::*;

  localparam int MetaDepth = 5;

  logic       ext_q, mirror_q;
  logic [7:0] strength_q;

  logic        front_valid;
  front_t      front;
  logic [15:0] fric_word;

  meta_t meta_d;
  meta_t meta_q [MetaDepth];

  logic       done_q, supported_q;
  logic [7:0] addr_q, data_low_q, data_high_q;
  logic [1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q      <= 1'b0;
      mirror_q   <= 1'b0;
      strength_q <= STRENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXTENDED: ext_q      <= cfg_wdata_i[0];
        CFG_MIRROR:   mirror_q   <= cfg_wdata_i[0];
        CFG_STRENGTH: strength_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  mpwe_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .ext_en_i            (ext_q),
    .strength_i          (strength_q),
    .op_i                (op_i),
    .setting_value_i     (setting_value_i),
    .auto_rotation_i     (auto_rotation_i),
    .auto_degrees_i      (auto_degrees_i),
    .ramp_percent_i      (ramp_percent_i),
    .calibration_active_i(calibration_active_i),
    .linear_scale_i      (linear_scale_i),
    .valid_o             (front_valid),
    .front_o             (front)
  );

  mpwe_fric u_fric (
    .clk_i (clk_i),
    .p0_i  (front.p0),
    .ramp_i(front.rampc),
    .str_i (front.strc),
    .word_o(fric_word)
  );

  // byte encoding for every setting but friction
  always_comb begin
    logic [11:0] sx;
    logic [7:0]  sq;
    logic [4:0]  f;
    logic [14:0] pct;
    logic [15:0] pq;
    logic        ok;
    logic [7:0]  d0;

    sx  = (front.deg < DEG_SPLIT) ? (DEG_BIAS - front.deg) : front.deg;
    sq  = div10(sx);
    f   = (front.lo > 8'(FILTER_MAX)) ? FILTER_MAX : front.lo[4:0];
    pct = {front.vcap, 8'd0} - 15'(front.vcap);
    pq  = div100(23'(pct));
    ok  = front.ok;
    d0  = 8'd0;

    case (front.op)
      OP_SENS:     d0 = (front.deg < DEG_SPLIT) ? (8'd0 - sq) : (sq + SENS_OFFSET);
      OP_FFB_STR:  d0 = front.lo;
      OP_SCALE:    d0 = front.lin ? LINEAR_CODE : 8'd0;
      OP_DAMPER,
      OP_INERTIA:  d0 = pq[7:0];
      OP_FRICTION: d0 = 8'd0;
      OP_FILTER: begin
        if (mirror_q && f <= FILTER_KNEE) begin
          d0 = {3'd0, FILTER_MIRROR - f};
        end else begin
          d0 = {3'd0, FILTER_MAX - f};
        end
      end
      OP_EFF_INT:  d0 = {1'b0, front.vcap};
      OP_EFF_STR,
      OP_SPR_STR,
      OP_DMP_STR:  d0 = (front.lo > EFFECT_MAX) ? EFFECT_MAX : front.lo;
      default:     ok = 1'b0;
    endcase

    meta_d.valid = front_valid;
    meta_d.ok    = ok;
    meta_d.op    = front.op;
    meta_d.d0    = d0;
  end

  // item metadata rides alongside the friction chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MetaDepth; i++) begin
        meta_q[i] <= '0;
      end
    end else begin
      meta_q[0] <= meta_d;
      for (int i = 1; i < MetaDepth; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= meta_q[MetaDepth-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_q[MetaDepth-1].ok) begin
      supported_q <= 1'b1;
      addr_q      <= ADDR_BASE + 8'(meta_q[MetaDepth-1].op);
      if (meta_q[MetaDepth-1].op == OP_FRICTION) begin
        len_q       <= 2'd2;
        data_low_q  <= fric_word[7:0];
        data_high_q <= fric_word[15:8];
      end else begin
        len_q       <= 2'd1;
        data_low_q  <= meta_q[MetaDepth-1].d0;
        data_high_q <= 8'd0;
      end
    end else begin
      supported_q <= 1'b0;
      addr_q      <= 8'd0;
      len_q       <= 2'd0;
      data_low_q  <= 8'd0;
      data_high_q <= 8'd0;
    end
  end

  // fully pipelined, never refuses a start
  assign busy_o          = 1'b0;
  assign done_o          = done_q;
  assign supported_o     = supported_q;
  assign motor_address_o = addr_q;
  assign write_length_o  = len_q;
  assign data_low_o      = data_low_q;
  assign data_high_o     = data_high_q;

endmodule
